>>> rtl/mcspg_pkg.sv
package mcspg_pkg;

  localparam int MODE_W    = 2;
  localparam int CHAN_W    = 3;
  localparam int PIN_W     = 3;
  localparam int ANGLE_W   = 8;
  localparam int PULSE_W   = 16;
  localparam int LEN_W     = 17;
  localparam int PERIOD_W  = 20;
  localparam int PROD_W    = PULSE_W + ANGLE_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int NUM_PINS_DEF     = 7;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = PERIOD_W'(20000);

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

  typedef struct packed {
    logic load;
    logic calc_start;
    logic div_step;
    logic commit;
  } mcspg_cmd_t;

  typedef struct packed {
    logic need_calc;
    logic ma_zero;
    logic div_last;
    logic out_free;
  } mcspg_sts_t;

endpackage

>>> rtl/mcspg_ctrl.sv
module mcspg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcspg_pkg::mcspg_sts_t sts,
  output mcspg_pkg::mcspg_cmd_t cmd
);
  import mcspg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = in_valid && (state_r == S_IDLE);
    cmd.calc_start = (state_r == S_CALC);
    cmd.div_step   = (state_r == S_DIV);
    cmd.commit     = (state_r == S_DONE) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_calc ? S_CALC : S_DONE;
        end
      end
      S_CALC: begin
        state_nxt = sts.ma_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_plain_item_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.need_calc) |=> (state_r == S_DONE))
    else $error("Item without a division did not go straight to completion.");

  a_div_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> (state_r == S_DONE))
    else $error("Division did not end in completion.");

  a_calc_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.need_calc) |=> cmd.calc_start)
    else $error("Angle calculation did not follow its command.");

endmodule

>>> rtl/mcspg_dp.sv
module mcspg_dp #(
  parameter int NUM_CHANNELS = mcspg_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_PINS     = mcspg_pkg::NUM_PINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mcspg_pkg::MODE_W-1:0]    in_mode,
  input  logic [mcspg_pkg::CHAN_W-1:0]    in_channel,
  input  logic [mcspg_pkg::PIN_W-1:0]     in_pin,
  input  logic [mcspg_pkg::ANGLE_W-1:0]   in_angle,
  input  logic [mcspg_pkg::ANGLE_W-1:0]   in_full_angle,
  input  logic [mcspg_pkg::PULSE_W-1:0]   in_min_pulse_us,
  input  logic [mcspg_pkg::PULSE_W-1:0]   in_max_pulse_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [NUM_PINS-1:0]             out_pin_levels,
  output logic                            out_frame_start,
  input  logic                            cfg_valid,
  input  logic [mcspg_pkg::PERIOD_W-1:0]  cfg_frame_period_us,
  input  mcspg_pkg::mcspg_cmd_t           cmd,
  output mcspg_pkg::mcspg_sts_t           sts
);
  import mcspg_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                chan_en_r    [NUM_CHANNELS];
  logic [PIN_W-1:0]    chan_pin_r   [NUM_CHANNELS];
  logic [PULSE_W-1:0]  chan_min_r   [NUM_CHANNELS];
  logic [PULSE_W-1:0]  chan_width_r [NUM_CHANNELS];
  logic [ANGLE_W-1:0]  chan_ma_r    [NUM_CHANNELS];
  logic [LEN_W-1:0]    chan_len_r   [NUM_CHANNELS];

  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] cnt_r;
  logic [PERIOD_W-1:0] cnt_nxt;
  logic [PERIOD_W:0]   cnt_inc;

  logic [MODE_W-1:0]   mode_r;
  logic [CH_IDX_W-1:0] idx_r;
  logic [ANGLE_W-1:0]  angle_r;

  logic [PROD_W-1:0]    q_r;
  logic [PROD_W-1:0]    q_nxt;
  logic [ANGLE_W-1:0]   rem_r;
  logic [ANGLE_W-1:0]   rem_nxt;
  logic [ANGLE_W-1:0]   ma_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [ANGLE_W:0]     trial;
  logic                 trial_ge;

  logic [ANGLE_W-1:0]  cur_ma;
  logic [ANGLE_W-1:0]  clamped;
  logic [PROD_W-1:0]   prod;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;

  logic [NUM_PINS-1:0] levels_nxt;
  logic [NUM_PINS-1:0] held_r;
  logic                fs_r;
  logic                out_valid_r;
  logic                is_tick;

  assign ch_ok   = (32'(in_channel) < NUM_CHANNELS);
  assign ch_idx  = CH_IDX_W'(in_channel);
  assign is_tick = (mode_r == MODE_TICK);

  assign cur_ma  = chan_ma_r[idx_r];
  assign clamped = (angle_r > cur_ma) ? cur_ma : angle_r;
  assign prod    = PROD_W'(chan_width_r[idx_r]) * PROD_W'(clamped);

  assign trial    = {rem_r, q_r[PROD_W-1]};
  assign trial_ge = (trial >= {1'b0, ma_r});
  assign rem_nxt  = trial_ge ? ANGLE_W'(trial - {1'b0, ma_r}) : trial[ANGLE_W-1:0];
  assign q_nxt    = {q_r[PROD_W-2:0], trial_ge};

  assign cnt_inc = {1'b0, cnt_r} + (PERIOD_W+1)'(1);
  assign cnt_nxt = (cnt_inc >= {1'b0, period_r}) ? '0 : cnt_inc[PERIOD_W-1:0];

  always_comb begin
    levels_nxt = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (chan_en_r[i] && (32'(chan_pin_r[i]) == p) &&
            (cnt_r < PERIOD_W'(chan_len_r[i]))) begin
          levels_nxt[p] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.need_calc = ch_ok && ((in_mode == MODE_ADD) || (in_mode == MODE_SET));
    sts.ma_zero   = (cur_ma == '0);
    sts.div_last  = (div_cnt_r == DIV_CNT_W'(PROD_W - 1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_en_r[i]    <= 1'b0;
        chan_pin_r[i]   <= '0;
        chan_min_r[i]   <= '0;
        chan_width_r[i] <= '0;
        chan_ma_r[i]    <= '0;
        chan_len_r[i]   <= '0;
      end
    end else begin
      if (cmd.load && ch_ok) begin
        if (in_mode == MODE_ADD) begin
          chan_en_r[ch_idx]    <= 1'b1;
          chan_pin_r[ch_idx]   <= in_pin;
          chan_min_r[ch_idx]   <= in_min_pulse_us;
          chan_width_r[ch_idx] <= in_max_pulse_us - in_min_pulse_us;
          chan_ma_r[ch_idx]    <= in_full_angle;
        end else if (in_mode == MODE_REMOVE) begin
          chan_en_r[ch_idx] <= 1'b0;
        end
      end
      if (cmd.calc_start && sts.ma_zero) begin
        chan_len_r[idx_r] <= LEN_W'(chan_min_r[idx_r]);
      end
      if (cmd.div_step && sts.div_last) begin
        chan_len_r[idx_r] <= LEN_W'(chan_min_r[idx_r]) + LEN_W'(q_nxt[PULSE_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      idx_r   <= ch_idx;
      angle_r <= in_angle;
    end
    if (cmd.calc_start) begin
      q_r       <= prod;
      rem_r     <= '0;
      ma_r      <= cur_ma;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= q_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= FRAME_PERIOD_RST;
      cnt_r       <= '0;
      held_r      <= '0;
      fs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        period_r <= cfg_frame_period_us;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (is_tick) begin
          held_r <= levels_nxt;
          fs_r   <= (cnt_r == '0);
          cnt_r  <= cnt_nxt;
        end else begin
          fs_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pin_levels  = held_r;
  assign out_frame_start = fs_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < ma_r))
    else $error("Division remainder reached the divisor.");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("Completed item did not present a result.");

  a_counter_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_tick && (period_r != '0) && !cfg_valid) |=> (cnt_r < period_r))
    else $error("Frame counter left the frame.");

endmodule

>>> rtl/multi_channel_servo_pulse_generator.sv
// Servo pulse generator. A tick item, a remove command or a command on a channel that
// does not exist goes from acceptance straight to completion; an add or set-angle command
// on a channel whose maximum angle is zero passes the calculation step first. An add or
// set-angle command otherwise passes, in order, acceptance, forming the product of pulse
// width and clamped angle, the bit-serial divider (the longest step) that divides it by
// the maximum angle, and handing over the result. One item is worked on at a time, and a
// result waits in the output register while the next item is accepted; completion waits
// only while that register is still held by a stall. The frame period can be written at
// any time the block is idle and takes effect from the next tick.
module multi_channel_servo_pulse_generator #(
  parameter int NUM_CHANNELS = mcspg_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_PINS     = mcspg_pkg::NUM_PINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mcspg_pkg::MODE_W-1:0]   in_mode,
  input  logic [mcspg_pkg::CHAN_W-1:0]   in_channel,
  input  logic [mcspg_pkg::PIN_W-1:0]    in_pin,
  input  logic [mcspg_pkg::ANGLE_W-1:0]  in_angle,
  input  logic [mcspg_pkg::ANGLE_W-1:0]  in_full_angle,
  input  logic [mcspg_pkg::PULSE_W-1:0]  in_min_pulse_us,
  input  logic [mcspg_pkg::PULSE_W-1:0]  in_max_pulse_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [NUM_PINS-1:0]            out_pin_levels,
  output logic                           out_frame_start,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcspg_pkg::PERIOD_W-1:0] cfg_frame_period_us
);
  import mcspg_pkg::*;

  mcspg_cmd_t cmd;
  mcspg_sts_t sts;

  assign cfg_ready = 1'b1;

  mcspg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcspg_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PINS     (NUM_PINS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mode             (in_mode),
    .in_channel          (in_channel),
    .in_pin              (in_pin),
    .in_angle            (in_angle),
    .in_full_angle       (in_full_angle),
    .in_min_pulse_us     (in_min_pulse_us),
    .in_max_pulse_us     (in_max_pulse_us),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pin_levels      (out_pin_levels),
    .out_frame_start     (out_frame_start),
    .cfg_valid           (cfg_valid),
    .cfg_frame_period_us (cfg_frame_period_us),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

>>> test/multi_channel_servo_pulse_generator_test.sv
`timescale 1ns / 100ps

module multi_channel_servo_pulse_generator_test;

  import mcspg_pkg::*;

  localparam int CHANNELS    = NUM_CHANNELS_DEF;
  localparam int PINS        = NUM_PINS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAN_W-1:0]  channel;
    logic [PIN_W-1:0]   pin;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] full_angle;
    logic [PULSE_W-1:0] min_us;
    logic [PULSE_W-1:0] max_us;
  } servo_cmd_t;

  typedef struct packed {
    logic [PINS-1:0] levels;
    logic            frame_start;
  } servo_levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode = MODE_TICK;
  logic [CHAN_W-1:0]   in_channel = '0;
  logic [PIN_W-1:0]    in_pin = '0;
  logic [ANGLE_W-1:0]  in_angle = '0;
  logic [ANGLE_W-1:0]  in_full_angle = '0;
  logic [PULSE_W-1:0]  in_min_pulse_us = '0;
  logic [PULSE_W-1:0]  in_max_pulse_us = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PINS-1:0]     out_pin_levels;
  logic                out_frame_start;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_frame_period_us = '0;

  logic hold_out = 1'b0;
  logic quiet = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_seen = 0;

  servo_levels_t pending_levels[$];

  logic                ch_on    [CHANNELS];
  logic [PIN_W-1:0]    ch_pin   [CHANNELS];
  logic [PULSE_W-1:0]  ch_min   [CHANNELS];
  logic [PULSE_W-1:0]  ch_span  [CHANNELS];
  logic [ANGLE_W-1:0]  ch_top   [CHANNELS];
  logic [LEN_W-1:0]    ch_len   [CHANNELS];
  logic [PERIOD_W-1:0] frame_pos;
  logic [PERIOD_W-1:0] frame_len;
  logic [PINS-1:0]     levels_now;

  multi_channel_servo_pulse_generator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_channel          (in_channel),
    .in_pin              (in_pin),
    .in_angle            (in_angle),
    .in_full_angle       (in_full_angle),
    .in_min_pulse_us     (in_min_pulse_us),
    .in_max_pulse_us     (in_max_pulse_us),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pin_levels      (out_pin_levels),
    .out_frame_start     (out_frame_start),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_frame_period_us (cfg_frame_period_us)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_levels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_out || (!quiet && $urandom_range(99) < 35);
  end

  function automatic logic [LEN_W-1:0] pulse_length(input logic [PULSE_W-1:0] base,
                                                    input logic [PULSE_W-1:0] span,
                                                    input logic [ANGLE_W-1:0] top,
                                                    input logic [ANGLE_W-1:0] ang);
    logic [PROD_W-1:0] extra;
    extra = '0;
    if (top != 0) begin
      if (ang > top) ang = top;
      extra = (span * ang) / top;
    end
    return {1'b0, base} + extra[LEN_W-1:0];
  endfunction

  function automatic servo_levels_t servo_predict(input servo_cmd_t c);
    servo_levels_t r;
    logic [PERIOD_W:0] nxt;
    r.levels = levels_now;
    r.frame_start = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        r.frame_start = (frame_pos == 0);
        r.levels = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_on[i] && ch_pin[i] < PINS && frame_pos < ch_len[i]) r.levels[ch_pin[i]] = 1'b1;
        end
        levels_now = r.levels;
        nxt = frame_pos + 1'b1;
        if (nxt >= {1'b0, frame_len}) nxt = '0;
        frame_pos = nxt[PERIOD_W-1:0];
      end
      MODE_ADD: begin
        ch_pin[c.channel]  = c.pin;
        ch_min[c.channel]  = c.min_us;
        ch_span[c.channel] = c.max_us - c.min_us;
        ch_top[c.channel]  = c.full_angle;
        ch_on[c.channel]   = 1'b1;
        ch_len[c.channel]  = pulse_length(c.min_us, ch_span[c.channel], c.full_angle, c.angle);
      end
      MODE_SET: begin
        ch_len[c.channel] = pulse_length(ch_min[c.channel], ch_span[c.channel],
                                         ch_top[c.channel], c.angle);
      end
      MODE_REMOVE: begin
        ch_on[c.channel] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic servo_cmd_t cmd(input logic [MODE_W-1:0] mode,
                                     input logic [CHAN_W-1:0] channel,
                                     input logic [PIN_W-1:0] pin,
                                     input logic [ANGLE_W-1:0] angle,
                                     input logic [ANGLE_W-1:0] full_angle,
                                     input logic [PULSE_W-1:0] min_us,
                                     input logic [PULSE_W-1:0] max_us);
    return '{mode, channel, pin, angle, full_angle, min_us, max_us};
  endfunction

  function automatic servo_cmd_t random_command(input int unsigned reach);
    servo_cmd_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) c.mode = MODE_TICK;
    else if (roll < 72) c.mode = MODE_ADD;
    else if (roll < 90) c.mode = MODE_SET;
    else c.mode = MODE_REMOVE;
    c.channel = CHAN_W'($urandom_range(CHANNELS - 1));
    c.pin = PIN_W'($urandom_range(7));
    c.angle = ANGLE_W'($urandom_range(255));
    c.full_angle = ($urandom_range(9) == 0) ? '0 : ANGLE_W'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      c.min_us = PULSE_W'($urandom);
      c.max_us = PULSE_W'($urandom);
    end else begin
      c.min_us = PULSE_W'($urandom_range(reach));
      c.max_us = PULSE_W'($urandom_range(reach + reach / 2));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errors++;
    if (errors <= 20) $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    servo_levels_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected beat", 0, 32'({out_pin_levels, out_frame_start}));
      end else begin
        want = pending_levels.pop_front();
        if (want.frame_start) frames_seen++;
        if (out_pin_levels !== want.levels)
          report_mismatch("pin_levels", 32'(want.levels), 32'(out_pin_levels));
        if (out_frame_start !== want.frame_start)
          report_mismatch("frame_start", 32'(want.frame_start), 32'(out_frame_start));
      end
    end
  end

  task automatic send_item(input servo_cmd_t c);
    if (!quiet) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_mode         <= c.mode;
    in_channel      <= c.channel;
    in_pin          <= c.pin;
    in_angle        <= c.angle;
    in_full_angle   <= c.full_angle;
    in_min_pulse_us <= c.min_us;
    in_max_pulse_us <= c.max_us;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_levels.push_back(servo_predict(c));
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    servo_cmd_t c;
    repeat (n) begin
      c = random_command(65535);
      c.mode = MODE_TICK;
      send_item(c);
    end
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_period(input logic [PERIOD_W-1:0] value);
    finish_phase();
    cfg_frame_period_us <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_len = value;
  endtask

  task automatic test_reset_state();
    send_ticks(3);
  endtask

  task automatic test_channel_commands();
    write_frame_period(6);
    send_item(cmd(MODE_ADD, 0, 0, 255, 255, 0, 16'hFFFF));
    send_item(cmd(MODE_ADD, 1, 6, 200, 3, 2, 5));
    send_item(cmd(MODE_ADD, 2, 7, 10, 10, 3, 9));
    send_item(cmd(MODE_ADD, 3, 3, 100, 0, 4, 60000));
    send_item(cmd(MODE_ADD, 4, 2, 1, 1, 16'hFFFF, 0));
    send_item(cmd(MODE_SET, 5, 0, 255, 0, 0, 0));
    send_ticks(7);
    send_item(cmd(MODE_SET, 1, 0, 0, 0, 0, 0));
    send_item(cmd(MODE_REMOVE, 0, 0, 0, 0, 0, 0));
    send_item(cmd(MODE_ADD, 7, 5, 0, 255, 0, 0));
    send_ticks(7);
    send_item(cmd(MODE_REMOVE, 4, 0, 0, 0, 0, 0));
    send_ticks(2);
  endtask

  task automatic test_frame_period_edges();
    write_frame_period(0);
    send_ticks(3);
    write_frame_period(1);
    send_ticks(3);
    write_frame_period(1000);
    send_ticks(40);
    write_frame_period(10);
    send_ticks(3);
    write_frame_period(20'hFFFFF);
    send_ticks(3);
    write_frame_period(1000000);
    send_ticks(3);
  endtask

  task automatic test_random_traffic();
    int unsigned reach;
    for (int phase = 0; phase < 4; phase++) begin
      write_frame_period(PERIOD_W'($urandom_range(2, 150)));
      reach = $urandom_range(4, 200);
      quiet = (phase == 2);
      repeat (400) send_item(random_command(reach));
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_holdoff();
    write_frame_period(20);
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
      repeat (40) send_item(random_command(30));
    join
  endtask

  initial begin
    frame_len  = FRAME_PERIOD_RST;
    frame_pos  = '0;
    levels_now = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_on[i]   = 1'b0;
      ch_pin[i]  = '0;
      ch_min[i]  = '0;
      ch_span[i] = '0;
      ch_top[i]  = '0;
      ch_len[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_channel_commands();
    test_frame_period_edges();
    test_random_traffic();
    test_output_holdoff();

    finish_phase();
    repeat (30) @(posedge clk);
    $display("Sent %0d items and checked %0d result beats, %0d of which began a frame.",
             items_sent, beats_checked, frames_seen);
    $display("Exercised every command, angle clamping, width wrap, frame periods from 0 to ",
             "the field maximum and a long output hold-off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
